// ----- src/ddss_pkg.sv -----
// ---------------------------------------------------------------------------
// ddss_pkg
// Shared constants, register indexes and the CORDIC arctangent table for
// the differential drive state step unit.
// ---------------------------------------------------------------------------
package ddss_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_BASE = 2'd1;

  localparam logic [DATA_W-1:0] TIME_STEP_RST      = 32'd6554;
  localparam logic [DATA_W-1:0] INV_WHEEL_BASE_RST = 32'd65536;

  // angle into the sine/cosine unit and trig values, both Q.30
  localparam int ANG_W  = 41;
  localparam int TRIG_W = 34;

  localparam logic [41:0]        TWO_PI_Q30  = 42'd6746518852;
  localparam logic signed [34:0] TWO_PI_S    = 35'sd6746518852;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [38:0] SINC_LIMIT_Q30 = 39'd1073742;
  localparam logic [33:0] DTH_LIMIT      = 34'h200000000;

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      24: r = 32'h0000003F;
      25: r = 32'h0000001F;
      26: r = 32'h0000000F;
      27: r = 32'h00000008;
      28: r = 32'h00000004;
      29: r = 32'h00000002;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- src/ddss_if.sv -----
// ---------------------------------------------------------------------------
// ddss interfaces
// Valid/ready channels for the state item, the result item and register
// writes.
// ---------------------------------------------------------------------------
interface ddss_item_if import ddss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] heading;
  logic signed [DATA_W-1:0] left_speed;
  logic signed [DATA_W-1:0] right_speed;
  logic signed [DATA_W-1:0] left_accel;
  logic signed [DATA_W-1:0] right_accel;

  modport source (output valid, pos_x, pos_y, heading, left_speed, right_speed,
                  left_accel, right_accel, input ready);
  modport sink (input valid, pos_x, pos_y, heading, left_speed, right_speed,
                left_accel, right_accel, output ready);
endinterface

interface ddss_result_if import ddss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] next_x;
  logic signed [DATA_W-1:0] next_y;
  logic signed [DATA_W-1:0] next_heading;
  logic signed [DATA_W-1:0] next_left_speed;
  logic signed [DATA_W-1:0] next_right_speed;
  logic                     overflow;

  modport source (output valid, next_x, next_y, next_heading, next_left_speed,
                  next_right_speed, overflow, input ready);
  modport sink (input valid, next_x, next_y, next_heading, next_left_speed,
                next_right_speed, overflow, output ready);
endinterface

interface ddss_cfg_if import ddss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/diff_drive_state_step_unit.sv -----
// ---------------------------------------------------------------------------
// diff_drive_state_step_unit
// Differential drive arc odometry: one state step per transaction.
// ---------------------------------------------------------------------------
// Takes one state transaction per clock unless stalled and returns the next
// state from the end of a pipeline that holds the CORDIC rotation chain and
// the 32-step radix-2 divider that forms sinc of the half turn; every stage
// is registered, so throughput is one item per cycle when not stalled. The
// pipeline stalls only when its last stage holds a result and the output
// register is still waiting. time_step and inverse_wheel_base should be
// written while no transaction is in flight.
module diff_drive_state_step_unit import ddss_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ddss_item_if.sink    item,
  ddss_result_if.source result,
  ddss_cfg_if.sink     cfg
);

  localparam int CL       = CORDIC_STAGES + 4;
  localparam int DIV_N    = 32;
  localparam int SINC_LAT = DIV_N + 2;
  localparam int LAST     = 7 + CL + SINC_LAT + 5;
  localparam int SIDE_D   = CL + SINC_LAT + 2;
  localparam int DSM_W    = 63 - FRAC_BITS;
  localparam int DS_W     = DSM_W + 1;
  localparam int HI_W     = DSM_W - 24;
  localparam int MP_W     = DSM_W + 35;
  localparam int MX_W     = MP_W - 29;
  localparam int REM_W    = 72;

  typedef struct packed {
    logic signed [31:0]     px;
    logic signed [31:0]     py;
    logic signed [31:0]     nh;
    logic signed [31:0]     vl;
    logic signed [31:0]     vr;
    logic                   ov;
    logic signed [DS_W-1:0] ds;
  } side_t;

  function automatic logic signed [95:0] tz(input logic signed [95:0] p, input int k);
    return p[95] ? -((-p) >>> k) : (p >>> k);
  endfunction

  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) r = {1'b1, 32'h7FFFFFFF};
    else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  // configuration
  logic [31:0] time_step, inverse_wheel_base;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step          <= TIME_STEP_RST;
      inverse_wheel_base <= INV_WHEEL_BASE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TIME_STEP:      time_step <= cfg.data;
        REG_INV_WHEEL_BASE: inverse_wheel_base <= cfg.data;
        default: ;
      endcase
    end
  end

  logic signed [32:0] dt_s, inv_s;
  assign dt_s  = $signed({1'b0, time_step});
  assign inv_s = $signed({1'b0, inverse_wheel_base});

  // flow control
  logic            ce;
  logic            out_en;
  logic [LAST:1]   vp;

  assign out_en     = !result.valid || result.ready;
  assign ce         = !vp[LAST] || out_en;
  assign item.ready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp           <= '0;
      result.valid <= 1'b0;
    end else begin
      if (ce) vp <= {vp[LAST-1:1], item.valid};
      if (out_en) result.valid <= vp[LAST];
    end
  end

  // stage 1: acceleration times step
  logic signed [64:0] p_al, p_ar;
  logic signed [31:0] s1_px, s1_py, s1_hd, s1_sl, s1_sr;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_al  <= item.left_accel * dt_s;
      p_ar  <= item.right_accel * dt_s;
      s1_px <= item.pos_x;
      s1_py <= item.pos_y;
      s1_hd <= item.heading;
      s1_sl <= item.left_speed;
      s1_sr <= item.right_speed;
    end
  end

  // stage 2: integrated wheel speeds
  logic [32:0] vl_sat, vr_sat;
  logic signed [31:0] s2_px, s2_py, s2_hd, s2_vl, s2_vr;
  logic               s2_ov;

  assign vl_sat = sat32(66'(s1_sl) + 66'(tz(96'(p_al), FRAC_BITS)));
  assign vr_sat = sat32(66'(s1_sr) + 66'(tz(96'(p_ar), FRAC_BITS)));

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_vl <= vl_sat[31:0];
      s2_vr <= vr_sat[31:0];
      s2_ov <= vl_sat[32] | vr_sat[32];
      s2_px <= s1_px;
      s2_py <= s1_py;
      s2_hd <= s1_hd;
    end
  end

  // stage 3: arc length and turn rate products
  logic signed [32:0] v_sum, v_diff;
  logic signed [65:0] p_ds, p_rate;
  logic signed [31:0] s3_px, s3_py, s3_hd, s3_vl, s3_vr;
  logic               s3_ov;

  assign v_sum  = 33'(s2_vl) + 33'(s2_vr);
  assign v_diff = 33'(s2_vr) - 33'(s2_vl);

  always_ff @(posedge clk) begin
    if (ce) begin
      p_ds   <= v_sum * dt_s;
      p_rate <= v_diff * inv_s;
      s3_px  <= s2_px;
      s3_py  <= s2_py;
      s3_hd  <= s2_hd;
      s3_vl  <= s2_vl;
      s3_vr  <= s2_vr;
      s3_ov  <= s2_ov;
    end
  end

  // stage 4: scale to Q.24 rate magnitude, capped
  logic [65:0] rate_abs;
  logic [81:0] rate_wide;
  logic [62:0] rate_cap;
  logic [62:0] s4_rate;
  logic        s4_neg;
  logic signed [DS_W-1:0] s4_ds;
  logic signed [31:0] s4_px, s4_py, s4_hd, s4_vl, s4_vr;
  logic               s4_ov;

  always_comb begin
    rate_abs  = p_rate[65] ? 66'(-p_rate) : 66'(p_rate);
    rate_wide = {rate_abs, 16'b0} >> (2 * FRAC_BITS - 8);
    rate_cap  = (rate_wide > 82'h4000000000000000) ? 63'h4000000000000000 : rate_wide[62:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_rate <= rate_cap;
      s4_neg  <= p_rate[65];
      s4_ds   <= DS_W'(tz(96'(p_ds), FRAC_BITS + 1));
      s4_px   <= s3_px;
      s4_py   <= s3_py;
      s4_hd   <= s3_hd;
      s4_vl   <= s3_vl;
      s4_vr   <= s3_vr;
      s4_ov   <= s3_ov;
    end
  end

  // stage 5: rate times step as two partial products
  logic [63:0] p_dlo;
  logic [62:0] p_dhi;
  logic        s5_neg;
  logic signed [DS_W-1:0] s5_ds;
  logic signed [31:0] s5_px, s5_py, s5_hd, s5_vl, s5_vr;
  logic               s5_ov;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_dlo  <= 64'(s4_rate[31:0]) * 64'(time_step);
      p_dhi  <= 63'(s4_rate[62:32]) * 63'(time_step);
      s5_neg <= s4_neg;
      s5_ds  <= s4_ds;
      s5_px  <= s4_px;
      s5_py  <= s4_py;
      s5_hd  <= s4_hd;
      s5_vl  <= s4_vl;
      s5_vr  <= s4_vr;
      s5_ov  <= s4_ov;
    end
  end

  // stage 6: heading change, clamped
  logic [95:0] dth_full, dth_shr;
  logic [33:0] dth_mag;
  logic signed [34:0] s6_dth;
  logic signed [DS_W-1:0] s6_ds;
  logic signed [31:0] s6_px, s6_py, s6_hd, s6_vl, s6_vr;
  logic               s6_ov;

  always_comb begin
    dth_full = {1'b0, p_dhi, 32'b0} + 96'(p_dlo);
    dth_shr  = dth_full >> FRAC_BITS;
    dth_mag  = (dth_shr > 96'(DTH_LIMIT)) ? DTH_LIMIT : dth_shr[33:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s6_dth <= s5_neg ? -$signed({1'b0, dth_mag}) : $signed({1'b0, dth_mag});
      s6_ds  <= s5_ds;
      s6_px  <= s5_px;
      s6_py  <= s5_py;
      s6_hd  <= s5_hd;
      s6_vl  <= s5_vl;
      s6_vr  <= s5_vr;
      s6_ov  <= s5_ov;
    end
  end

  // stage 7: half turn, mid heading, next heading
  logic signed [35:0] hd_sum;
  logic [32:0]        hd_sat;
  logic signed [39:0] s7_h;
  logic signed [ANG_W-1:0] s7_mid;
  side_t              s7_side;

  assign hd_sum = 36'(s6_hd) + 36'(s6_dth);
  assign hd_sat = sat32(66'(hd_sum));

  always_ff @(posedge clk) begin
    if (ce) begin
      s7_h       <= {s6_dth, 5'b0};
      s7_mid     <= ANG_W'($signed({s6_hd, 6'b0})) + ANG_W'($signed({s6_dth, 5'b0}));
      s7_side.px <= s6_px;
      s7_side.py <= s6_py;
      s7_side.nh <= hd_sat[31:0];
      s7_side.vl <= s6_vl;
      s7_side.vr <= s6_vr;
      s7_side.ov <= s6_ov | hd_sat[32];
      s7_side.ds <= s6_ds;
    end
  end

  // sine/cosine of mid heading and of half turn
  logic signed [TRIG_W-1:0] mid_c, mid_s, h_c, h_s;

  ddss_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_mid (
    .clk   (clk),
    .ce    (ce),
    .angle (s7_mid),
    .cos_q (mid_c),
    .sin_q (mid_s)
  );

  ddss_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_half (
    .clk   (clk),
    .ce    (ce),
    .angle (ANG_W'(s7_h)),
    .cos_q (h_c),
    .sin_q (h_s)
  );

  // delay lines
  logic signed [39:0]       h_dl  [0:CL-1];
  side_t                    sd_dl [0:SIDE_D-1];
  logic signed [TRIG_W-1:0] c_dl  [0:SINC_LAT-1];
  logic signed [TRIG_W-1:0] s_dl  [0:SINC_LAT-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      h_dl[0]  <= s7_h;
      sd_dl[0] <= s7_side;
      c_dl[0]  <= mid_c;
      s_dl[0]  <= mid_s;
      for (int k = 1; k < CL; k++) h_dl[k] <= h_dl[k-1];
      for (int k = 1; k < SIDE_D; k++) sd_dl[k] <= sd_dl[k-1];
      for (int k = 1; k < SINC_LAT; k++) begin
        c_dl[k] <= c_dl[k-1];
        s_dl[k] <= s_dl[k-1];
      end
    end
  end

  // sinc setup: series below the limit, else sin(h) / h
  logic signed [39:0] hh;
  logic [38:0]        hm;
  logic [41:0]        hsq;
  logic [11:0]        h2;
  logic [27:0]        h2_div6;
  logic [32:0]        hs_abs;

  logic [REM_W-1:0]   dv_rem [0:DIV_N];
  logic [38:0]        dv_den [0:DIV_N];
  logic [31:0]        dv_q   [0:DIV_N];
  logic               dv_neg [0:DIV_N];
  logic               dv_sml [0:DIV_N];
  logic signed [33:0] dv_scs [0:DIV_N];

  always_comb begin
    hh      = h_dl[CL-1];
    hm      = hh[39] ? 39'(-hh) : 39'(hh);
    hsq     = 42'(hm[20:0]) * 42'(hm[20:0]);
    h2      = hsq[41:30];
    // quartic term stays below one lsb over the series range
    h2_div6 = (28'(h2) * 28'd10923) >> 16;
    hs_abs  = h_s[TRIG_W-1] ? 33'(-h_s) : 33'(h_s);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dv_rem[0] <= REM_W'({hs_abs, 30'b0});
      dv_den[0] <= hm;
      dv_q[0]   <= '0;
      dv_neg[0] <= h_s[TRIG_W-1] ^ hh[39];
      dv_sml[0] <= hm < SINC_LIMIT_Q30;
      dv_scs[0] <= 34'sd1073741824 - $signed({6'b0, h2_div6});
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    localparam int B = DIV_N - 1 - k;
    logic [REM_W-1:0] trial;
    assign trial = REM_W'(dv_den[k]) << B;
    always_ff @(posedge clk) begin
      if (ce) begin
        if (dv_rem[k] >= trial) begin
          dv_rem[k+1] <= dv_rem[k] - trial;
          dv_q[k+1]   <= dv_q[k] | (32'd1 << B);
        end else begin
          dv_rem[k+1] <= dv_rem[k];
          dv_q[k+1]   <= dv_q[k];
        end
        dv_den[k+1] <= dv_den[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_sml[k+1] <= dv_sml[k];
        dv_scs[k+1] <= dv_scs[k];
      end
    end
  end

  logic signed [33:0] sc;
  logic signed [33:0] sc_q;

  assign sc_q = $signed({2'b00, dv_q[DIV_N]});

  always_ff @(posedge clk) begin
    if (ce) begin
      sc <= dv_sml[DIV_N] ? dv_scs[DIV_N] : (dv_neg[DIV_N] ? -sc_q : sc_q);
    end
  end

  // direction factors
  logic signed [67:0] p_fx, p_fy;
  logic signed [95:0] fx_t, fy_t;
  logic [34:0]        fxm, fym;
  logic               fxn, fyn;

  assign fx_t = tz(96'(p_fx), 30);
  assign fy_t = tz(96'(p_fy), 30);

  always_ff @(posedge clk) begin
    if (ce) begin
      p_fx <= sc * c_dl[SINC_LAT-1];
      p_fy <= sc * s_dl[SINC_LAT-1];
      fxm  <= fx_t[95] ? 35'(-fx_t) : 35'(fx_t);
      fym  <= fy_t[95] ? 35'(-fy_t) : 35'(fy_t);
      fxn  <= fx_t[95];
      fyn  <= fy_t[95];
    end
  end

  // displacement, split arc length times factor
  side_t              sd_g;
  logic [DSM_W-1:0]   dsm;
  logic [58:0]        pxl, pyl;
  logic [HI_W+34:0]   pxh, pyh;
  logic               g1_nx, g1_ny;
  side_t              g1_side;

  assign sd_g = sd_dl[SIDE_D-1];
  assign dsm  = sd_g.ds[DS_W-1] ? DSM_W'(-sd_g.ds) : DSM_W'(sd_g.ds);

  always_ff @(posedge clk) begin
    if (ce) begin
      pxl     <= 59'(dsm[23:0]) * 59'(fxm);
      pyl     <= 59'(dsm[23:0]) * 59'(fym);
      pxh     <= (HI_W+35)'(dsm[DSM_W-1:24]) * (HI_W+35)'(fxm);
      pyh     <= (HI_W+35)'(dsm[DSM_W-1:24]) * (HI_W+35)'(fym);
      g1_nx   <= sd_g.ds[DS_W-1] ^ fxn;
      g1_ny   <= sd_g.ds[DS_W-1] ^ fyn;
      g1_side <= sd_g;
    end
  end

  logic [MP_W-1:0]        mx_full, my_full;
  logic [MP_W-31:0]       mx_mag, my_mag;
  logic signed [MX_W-1:0] g2_mx, g2_my;
  side_t                  g2_side;

  always_comb begin
    mx_full = {pxh, 24'b0} + MP_W'(pxl);
    my_full = {pyh, 24'b0} + MP_W'(pyl);
    mx_mag  = mx_full[MP_W-1:30];
    my_mag  = my_full[MP_W-1:30];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      g2_mx   <= g1_nx ? -$signed({1'b0, mx_mag}) : $signed({1'b0, mx_mag});
      g2_my   <= g1_ny ? -$signed({1'b0, my_mag}) : $signed({1'b0, my_mag});
      g2_side <= g1_side;
    end
  end

  // final position, saturated
  logic [32:0] nx_sat, ny_sat;
  logic signed [31:0] g3_nx, g3_ny, g3_nh, g3_vl, g3_vr;
  logic               g3_ov;

  assign nx_sat = sat32(66'(g2_side.px) + 66'(g2_mx));
  assign ny_sat = sat32(66'(g2_side.py) + 66'(g2_my));

  always_ff @(posedge clk) begin
    if (ce) begin
      g3_nx <= nx_sat[31:0];
      g3_ny <= ny_sat[31:0];
      g3_nh <= g2_side.nh;
      g3_vl <= g2_side.vl;
      g3_vr <= g2_side.vr;
      g3_ov <= g2_side.ov | nx_sat[32] | ny_sat[32];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_en) begin
      result.next_x           <= g3_nx;
      result.next_y           <= g3_ny;
      result.next_heading     <= g3_nh;
      result.next_left_speed  <= g3_vl;
      result.next_right_speed <= g3_vr;
      result.overflow         <= g3_ov;
    end
  end

endmodule

// ----- src/ddss_cordic.sv -----
// ---------------------------------------------------------------------------
// ddss_cordic
// Pipelined sine/cosine of a Q.30 angle in [-256*pi, 256*pi): modulo 2*pi
// reduction over two stages, quadrant fold, one rotation stage per CORDIC step.
// ---------------------------------------------------------------------------
module ddss_cordic import ddss_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     ce,
  input  logic signed [ANG_W-1:0]  angle,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q
);

  localparam int RED_W = 42;
  localparam logic [RED_W-1:0] OFFSET = TWO_PI_Q30 << 7;

  logic [RED_W-1:0] red_a, red_b, ua, ub;
  logic signed [34:0] zr, zf;
  logic               flip;

  logic signed [TRIG_W-1:0] xs [0:STAGES];
  logic signed [TRIG_W-1:0] ys [0:STAGES];
  logic signed [TRIG_W-1:0] zs [0:STAGES];
  logic                     fl [0:STAGES];

  always_comb begin
    ua = RED_W'(angle) + OFFSET;
    for (int j = 7; j >= 4; j--) begin
      if (ua >= (TWO_PI_Q30 << j)) ua = ua - (TWO_PI_Q30 << j);
    end
    ub = red_a;
    for (int j = 3; j >= 0; j--) begin
      if (ub >= (TWO_PI_Q30 << j)) ub = ub - (TWO_PI_Q30 << j);
    end
  end

  always_comb begin
    zr = $signed({2'b00, red_b[32:0]});
    if (zr > PI_Q30) zr = zr - TWO_PI_S;
    flip = 1'b0;
    zf = zr;
    if (zr > HALF_PI_Q30) begin
      zf = zr - PI_Q30;
      flip = 1'b1;
    end else if (zr < -HALF_PI_Q30) begin
      zf = zr + PI_Q30;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      red_a <= ua;
      red_b <= ub;
      xs[0] <= CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= zf[TRIG_W-1:0];
      fl[0] <= flip;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [TRIG_W-1:0] ATAN = $signed({2'b00, atan_q30(i)});
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!zs[i][TRIG_W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN;
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cos_q <= fl[STAGES] ? -xs[STAGES] : xs[STAGES];
      sin_q <= fl[STAGES] ? -ys[STAGES] : ys[STAGES];
    end
  end

endmodule

// ----- dv/diff_drive_state_step_unit_test.sv -----
// ---------------------------------------------------------------------------
// diff_drive_state_step_unit_test
// Drives random and directed robot states through the arc odometry step unit
// and checks every result transaction against a bit-exact predictor kept here.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module diff_drive_state_step_unit_test;
  import ddss_pkg::*;

  localparam int N_STAGES  = CORDIC_STAGES_DEF;
  localparam int FBITS     = FRAC_BITS_DEF;
  localparam int PIPE_LAT  = N_STAGES + 50;
  localparam int IDLE_MAX  = 20000;
  localparam logic signed [63:0] Q30_ONE  = 64'sd1 << 30;
  localparam logic signed [63:0] CAP62    = 64'sd1 << 62;
  localparam logic signed [63:0] TWO_PI_L = 64'sd6746518852;
  localparam logic signed [63:0] PI_L     = 64'sd3373259426;
  localparam logic signed [63:0] HPI_L    = 64'sd1686629713;
  localparam logic signed [63:0] GAIN_L   = 64'sd652032874;
  localparam logic signed [63:0] SINC_LIM = 64'sd1073742;
  localparam logic signed [63:0] DTH_LIM  = 64'sd1 << 33;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] hd;
    logic signed [31:0] vl;
    logic signed [31:0] vr;
    logic               ov;
  } step_result_t;

  logic clk;
  logic rst;
  ddss_item_if   item ();
  ddss_result_if result ();
  ddss_cfg_if    cfg ();

  diff_drive_state_step_unit u_top (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source), .cfg(cfg.sink)
  );

  logic [31:0] dt_reg;
  logic [31:0] inv_reg;
  step_result_t expected_q[$];
  int errors;
  int idle_cycles;
  int sink_stall_max;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    if ((item.valid && item.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_MAX) begin
        $display("diff_drive_state_step_unit test failed");
        $finish;
      end
    end
  end

  function automatic logic signed [63:0] mul_sh(logic signed [63:0] a,
                                                logic signed [63:0] b, int k);
    logic [63:0] ma, mb;
    logic [127:0] p;
    logic [127:0] q;
    logic signed [63:0] r;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p = ma * mb;
    q = p >> k;
    r = (q > 128'(CAP62)) ? CAP62 : $signed(q[63:0]);
    return (a[63] != b[63]) ? -r : r;
  endfunction

  function automatic logic signed [63:0] sat_32(logic signed [63:0] v, ref logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void rotate_q30(input logic signed [63:0] ang,
                                     output logic signed [63:0] c,
                                     output logic signed [63:0] s);
    logic signed [63:0] z, x, y, dx, dy;
    logic flip;
    z = ang % TWO_PI_L;
    x = GAIN_L;
    y = 0;
    flip = 1'b0;
    if (z < 0) z += TWO_PI_L;
    if (z > PI_L) z -= TWO_PI_L;
    if (z > HPI_L) begin
      z -= PI_L;
      flip = 1'b1;
    end else if (z < -HPI_L) begin
      z += PI_L;
      flip = 1'b1;
    end
    for (int i = 0; i < N_STAGES && i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= $signed({32'd0, atan_q30(i)});
      end else begin
        x += dx;
        y -= dy;
        z += $signed({32'd0, atan_q30(i)});
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [63:0] sinc_half_turn(logic signed [63:0] h);
    logic signed [63:0] hm, c, s;
    logic [63:0] h2, h4;
    hm = h[63] ? -h : h;
    if (hm < SINC_LIM) begin
      h2 = (hm * hm) >> 30;
      h4 = (h2 * h2) >> 30;
      return Q30_ONE - $signed(h2 / 6) + $signed(h4 / 120);
    end
    rotate_q30(h, c, s);
    return (s * Q30_ONE) / h;
  endfunction

  function automatic step_result_t predict_step(logic signed [31:0] px, py, hd, sl, sr,
                                                al, ar);
    logic signed [63:0] dt, inv, vl, vr, ds, rate, dth, h, mid, c, s, sc, fx, fy;
    logic ov;
    step_result_t r;
    ov = 1'b0;
    dt = $signed({32'd0, dt_reg});
    inv = $signed({32'd0, inv_reg});
    vl = sat_32(64'(sl) + mul_sh(64'(al), dt, FBITS), ov);
    vr = sat_32(64'(sr) + mul_sh(64'(ar), dt, FBITS), ov);
    ds = mul_sh(vl + vr, dt, FBITS + 1);
    rate = mul_sh((vr - vl) * (64'sd1 <<< (24 - FBITS)), inv, FBITS);
    dth = mul_sh(rate, dt, FBITS);
    if (dth > DTH_LIM) dth = DTH_LIM;
    if (dth < -DTH_LIM) dth = -DTH_LIM;
    h = dth * 32;
    mid = 64'(hd) * 64 + h;
    rotate_q30(mid, c, s);
    sc = sinc_half_turn(h);
    fx = mul_sh(sc, c, 30);
    fy = mul_sh(sc, s, 30);
    r.x  = 32'(sat_32(64'(px) + mul_sh(ds, fx, 30), ov));
    r.y  = 32'(sat_32(64'(py) + mul_sh(ds, fy, 30), ov));
    r.hd = 32'(sat_32(64'(hd) + dth, ov));
    r.vl = 32'(vl);
    r.vr = 32'(vr);
    r.ov = ov;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // result checker with random backpressure
  initial begin
    int stall;
    step_result_t e;
    result.ready = 1'b0;
    errors = 0;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected transaction next_x=%h", $time, result.next_x);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (result.next_x !== e.x)
            $display("%0t next_x exp %h got %h", $time, e.x, result.next_x);
          if (result.next_y !== e.y)
            $display("%0t next_y exp %h got %h", $time, e.y, result.next_y);
          if (result.next_heading !== e.hd)
            $display("%0t next_heading exp %h got %h", $time, e.hd, result.next_heading);
          if (result.next_left_speed !== e.vl)
            $display("%0t next_left_speed exp %h got %h", $time, e.vl,
                     result.next_left_speed);
          if (result.next_right_speed !== e.vr)
            $display("%0t next_right_speed exp %h got %h", $time, e.vr,
                     result.next_right_speed);
          if (result.overflow !== e.ov)
            $display("%0t overflow exp %b got %b", $time, e.ov, result.overflow);
          if (result.next_x !== e.x || result.next_y !== e.y ||
              result.next_heading !== e.hd || result.next_left_speed !== e.vl ||
              result.next_right_speed !== e.vr || result.overflow !== e.ov)
            errors++;
        end
      end
      if (stall > 0) begin
        stall--;
        result.ready <= 1'b0;
      end else if (sink_stall_max > 0) begin
        stall = gap_len();
        result.ready <= (stall == 0);
        if (stall > 0) stall--;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  task automatic send_state(input logic [31:0] px, py, hd, sl, sr, al, ar, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      item.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.pos_x <= px;
    item.pos_y <= py;
    item.heading <= hd;
    item.left_speed <= sl;
    item.right_speed <= sr;
    item.left_accel <= al;
    item.right_accel <= ar;
    expected_q.push_back(predict_step(px, py, hd, sl, sr, al, ar));
    do @(posedge clk); while (!item.ready);
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_TIME_STEP) dt_reg = val;
    else if (idx == REG_INV_WHEEL_BASE) inv_reg = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 131072)) :
                                       -32'($urandom_range(0, 131072));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] ext[4];
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    send_state(0, 0, 0, 0, 0, 0, 0, 0);
    send_state(32'h10000, 32'h20000, 32'h0100_0000, 32'h10000, 32'h10000, 0, 0, 0);
    // small turn (sinc series)
    send_state(0, 0, 0, 32'h10000, 32'h10010, 0, 0, 0);
    // folded angles past half pi
    send_state(0, 0, 32'h0300_0000, 32'h10000, 32'h30000, 0, 0, 0);
    send_state(0, 0, 32'hfd00_0000, 32'h30000, 32'h10000, 0, 0, 0);
    // huge turn and saturation
    send_state(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_state(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff, 0);
    foreach (ext[i])
      send_state(ext[i], ext[3-i], ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4],
                 ext[i], 0);
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_state(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), 1);
      else
        send_state($urandom, $urandom, $urandom, 32'($signed(20'($urandom))),
                   32'($signed(20'($urandom))), 32'($signed(20'($urandom))),
                   32'($signed(20'($urandom))), (i % 200) > 30);
    end
    drain();
  endtask

  task automatic test_register_sweep();
    write_reg(REG_TIME_STEP, 32'hffff_ffff);
    write_reg(REG_INV_WHEEL_BASE, 32'hffff_ffff);
    test_random(150);
    write_reg(REG_TIME_STEP, 0);
    write_reg(REG_INV_WHEEL_BASE, 0);
    test_random(150);
    write_reg(2'd3, 32'h1234_5678);
    write_reg(REG_TIME_STEP, 32'h0001_0000);
    write_reg(REG_INV_WHEEL_BASE, 32'h0002_0000);
    test_random(300);
    write_reg(REG_TIME_STEP, $urandom_range(1, 65536));
    write_reg(REG_INV_WHEEL_BASE, $urandom);
    test_random(300);
    write_reg(REG_TIME_STEP, TIME_STEP_RST);
    write_reg(REG_INV_WHEEL_BASE, INV_WHEEL_BASE_RST);
  endtask

  initial begin
    rst = 1'b1;
    item.valid = 1'b0;
    item.pos_x = '0;
    item.pos_y = '0;
    item.heading = '0;
    item.left_speed = '0;
    item.right_speed = '0;
    item.left_accel = '0;
    item.right_accel = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    dt_reg = TIME_STEP_RST;
    inv_reg = INV_WHEEL_BASE_RST;
    idle_cycles = 0;
    sink_stall_max = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    sink_stall_max = 1;
    test_random(1100);
    test_register_sweep();
    if (errors == 0) begin
      $display("diff_drive_state_step_unit test passed");
    end else begin
      $display("diff_drive_state_step_unit test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ddss_pkg.sv
src/ddss_if.sv
src/ddss_cordic.sv
src/diff_drive_state_step_unit.sv
dv/diff_drive_state_step_unit_test.sv
